// ----- design/lscs_pkg.sv -----
// Shared types and constants of the line sensor calibration sequencer.
// Used by lscs_step and line_sensor_calibration_sequencer_core; no dependencies.
`default_nettype none

package lscs_pkg;

   // field widths
   localparam int unsigned LEVEL_W = 10;
   localparam int unsigned SPEED_W = 8;
   localparam int unsigned TIME_W  = 13;
   localparam int unsigned EVENT_W = 2;
   localparam int unsigned CSR_INDEX_W = 3;
   localparam int unsigned CSR_DATA_W  = 13;
   localparam int unsigned REQ_DATA_W  = 56;
   localparam int unsigned RSP_DATA_W  = 24;

   // register reset values
   localparam logic [SPEED_W-1:0] TURN_SPEED_RST      = 8'd30;
   localparam logic [SPEED_W-1:0] CENTER_SPEED_RST    = 8'd25;
   localparam logic [TIME_W-1:0]  TIMEOUT_MS_RST      = 13'd5000;
   localparam logic [LEVEL_W-1:0] OVER_LINE_LEVEL_RST = 10'd600;
   localparam logic [LEVEL_W-1:0] NO_LINE_LEVEL_RST   = 10'd400;

   // register indexes on the configuration port
   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_TURN_SPEED      = 3'd0,
      CSR_CENTER_SPEED    = 3'd1,
      CSR_TIMEOUT_MS      = 3'd2,
      CSR_OVER_LINE_LEVEL = 3'd3,
      CSR_NO_LINE_LEVEL   = 3'd4
   } csr_index_type;

   // sequencer phases
   typedef enum logic [2:0] {
      PH_WAIT   = 3'd0,
      PH_RIGHT  = 3'd1,
      PH_LEFT   = 3'd2,
      PH_CENTER = 3'd3,
      PH_DONE   = 3'd4,
      PH_FAIL   = 3'd5
   } phase_type;

   // event codes
   typedef enum logic [EVENT_W-1:0] {
      EV_NONE    = 2'd0,
      EV_SUCCESS = 2'd1,
      EV_FAILED  = 2'd2
   } event_type;

   typedef struct packed {
      logic [SPEED_W-1:0] turn_speed;
      logic [SPEED_W-1:0] center_speed;
      logic [TIME_W-1:0]  timeout_ms;
      logic [LEVEL_W-1:0] over_line_level;
      logic [LEVEL_W-1:0] no_line_level;
   } cfg_type;

   typedef struct packed {
      logic               restart;
      logic               ms_tick;
      logic [LEVEL_W-1:0] left_level;
      logic [LEVEL_W-1:0] mid_left_level;
      logic [LEVEL_W-1:0] mid_level;
      logic [LEVEL_W-1:0] mid_right_level;
      logic [LEVEL_W-1:0] right_level;
      logic               left_cal_ok;
      logic               right_cal_ok;
      logic               all_cal_ok;
   } req_item_type;

   typedef struct packed {
      logic               drive_valid;
      logic [SPEED_W-1:0] left_speed;
      logic               left_reverse;
      logic [SPEED_W-1:0] right_speed;
      logic               right_reverse;
      logic               cal_begin;
      logic               cal_end;
      event_type          event_code;
   } rsp_item_type;

   typedef struct packed {
      phase_type         phase;
      logic [TIME_W-1:0] time_left;
   } seq_state_type;

endpackage

`default_nettype wire

// ----- design/lscs_step.sv -----
// Next-state and result logic for one step of the calibration sequencer.
// Purely combinational; depends on lscs_pkg.
`default_nettype none

module lscs_step (
   input  lscs_pkg::cfg_type       cfg,
   input  lscs_pkg::req_item_type  item,
   input  lscs_pkg::seq_state_type cur,
   output lscs_pkg::seq_state_type nxt,
   output lscs_pkg::rsp_item_type  rsp
);

   lscs_pkg::phase_type             ph;
   logic [lscs_pkg::TIME_W-1:0]     tl;
   logic                            expired;
   logic                            left_over;
   logic                            right_over;
   logic                            centered;

   // apply restart, then count down one millisecond
   always_comb begin
      ph = item.restart ? lscs_pkg::PH_WAIT : cur.phase;
      tl = item.restart ? '0 : cur.time_left;
      if (item.ms_tick && (tl != '0)) begin
         tl = tl - 1'b1;
      end
   end

   // line detection
   assign expired    = (tl == '0);
   assign left_over  = item.left_level > cfg.over_line_level;
   assign right_over = item.right_level > cfg.over_line_level;
   assign centered   = (item.left_level < cfg.no_line_level) &&
                       (item.mid_left_level < cfg.no_line_level) &&
                       (item.mid_level > cfg.over_line_level) &&
                       (item.mid_right_level < cfg.no_line_level) &&
                       (item.right_level < cfg.no_line_level);

   // next phase and countdown
   always_comb begin
      nxt.phase     = ph;
      nxt.time_left = tl;
      case (ph)
         lscs_pkg::PH_RIGHT: begin
            if (expired) nxt.phase = lscs_pkg::PH_FAIL;
            if (item.left_cal_ok && left_over) begin
               nxt.phase     = lscs_pkg::PH_LEFT;
               nxt.time_left = cfg.timeout_ms;
            end
         end
         lscs_pkg::PH_LEFT: begin
            if (expired) nxt.phase = lscs_pkg::PH_FAIL;
            if (item.right_cal_ok && right_over) begin
               if (!item.all_cal_ok) begin
                  nxt.phase = lscs_pkg::PH_RIGHT;
               end else begin
                  nxt.phase     = lscs_pkg::PH_CENTER;
                  nxt.time_left = cfg.timeout_ms;
               end
            end
         end
         lscs_pkg::PH_CENTER: begin
            if (expired) nxt.phase = lscs_pkg::PH_FAIL;
            if (centered) begin
               nxt.phase     = lscs_pkg::PH_DONE;
               nxt.time_left = '0;
            end
         end
         lscs_pkg::PH_DONE: begin
            nxt.phase = lscs_pkg::PH_WAIT;
         end
         lscs_pkg::PH_FAIL: begin
            nxt.phase = lscs_pkg::PH_FAIL;
         end
         default: begin
            nxt.phase = lscs_pkg::PH_WAIT;
            if (expired) begin
               nxt.phase     = lscs_pkg::PH_RIGHT;
               nxt.time_left = cfg.timeout_ms;
            end
         end
      endcase
   end

   // result fields
   always_comb begin
      rsp = '0;
      case (ph)
         lscs_pkg::PH_RIGHT: begin
            rsp.drive_valid   = 1'b1;
            rsp.left_speed    = cfg.turn_speed;
            rsp.right_speed   = cfg.turn_speed;
            rsp.right_reverse = 1'b1;
         end
         lscs_pkg::PH_LEFT: begin
            rsp.drive_valid  = 1'b1;
            rsp.left_speed   = cfg.turn_speed;
            rsp.left_reverse = 1'b1;
            rsp.right_speed  = cfg.turn_speed;
         end
         lscs_pkg::PH_CENTER: begin
            rsp.drive_valid   = 1'b1;
            rsp.right_reverse = 1'b1;
            // stop the motors once centered
            if (!centered) begin
               rsp.left_speed  = cfg.center_speed;
               rsp.right_speed = cfg.center_speed;
            end
         end
         lscs_pkg::PH_DONE: begin
            rsp.cal_end    = 1'b1;
            rsp.event_code = lscs_pkg::EV_SUCCESS;
         end
         lscs_pkg::PH_FAIL: begin
            rsp.drive_valid   = 1'b1;
            rsp.right_reverse = 1'b1;
            rsp.cal_end       = 1'b1;
            rsp.event_code    = lscs_pkg::EV_FAILED;
         end
         default: begin
            rsp.cal_begin = expired;
         end
      endcase
   end

endmodule

`default_nettype wire

// ----- design/line_sensor_calibration_sequencer_core.sv -----
// Top level of the line sensor calibration sequencer: channels, registers, state.
// Depends on lscs_pkg and lscs_step.
//
//   channel  direction  handshake            payload
//   req      in         req_tvalid/tready    req_tdata  (56 bit step transaction)
//   rsp      out        rsp_tvalid/tready    rsp_tdata  (24 bit result transaction)
//   csr      in         csr_we               csr_index, csr_wdata
//
// One transaction per cycle unless the result stalls. A request lands in
// an input register, then the step logic updates phase and countdown and
// loads the result register. A stalled result holds both stages; the input
// register still takes one more transaction. Synchronous reset returns to
// the wait phase with an expired countdown and default registers.
`default_nettype none

module line_sensor_calibration_sequencer_core (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              req_tvalid,
   output logic                                   req_tready,
   // restart[0], ms_tick[1], left_level[11:2], mid_left_level[21:12],
   // mid_level[31:22], mid_right_level[41:32], right_level[51:42],
   // left_cal_ok[52], right_cal_ok[53], all_cal_ok[54], zero[55]
   input  wire logic [lscs_pkg::REQ_DATA_W-1:0]   req_tdata,
   output logic                                   rsp_tvalid,
   input  wire logic                              rsp_tready,
   // drive_valid[0], left_speed[8:1], left_reverse[9], right_speed[17:10],
   // right_reverse[18], cal_begin[19], cal_end[20], event_code[22:21], zero[23]
   output logic [lscs_pkg::RSP_DATA_W-1:0]        rsp_tdata,
   input  wire logic                              csr_we,
   input  wire logic [lscs_pkg::CSR_INDEX_W-1:0]  csr_index,
   input  wire logic [lscs_pkg::CSR_DATA_W-1:0]   csr_wdata
);

   lscs_pkg::cfg_type       cfg_ff;
   lscs_pkg::seq_state_type state_ff;
   lscs_pkg::seq_state_type state_in;
   lscs_pkg::req_item_type  item_ff;
   lscs_pkg::req_item_type  item_in;
   lscs_pkg::rsp_item_type  rsp_ff;
   lscs_pkg::rsp_item_type  rsp_in;
   logic                    item_valid_ff;
   logic                    rsp_valid_ff;
   logic                    advance;
   logic                    req_take;

   // configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.turn_speed      <= lscs_pkg::TURN_SPEED_RST;
         cfg_ff.center_speed    <= lscs_pkg::CENTER_SPEED_RST;
         cfg_ff.timeout_ms      <= lscs_pkg::TIMEOUT_MS_RST;
         cfg_ff.over_line_level <= lscs_pkg::OVER_LINE_LEVEL_RST;
         cfg_ff.no_line_level   <= lscs_pkg::NO_LINE_LEVEL_RST;
      end else if (csr_we) begin
         case (csr_index)
            lscs_pkg::CSR_TURN_SPEED:
               cfg_ff.turn_speed <= csr_wdata[lscs_pkg::SPEED_W-1:0];
            lscs_pkg::CSR_CENTER_SPEED:
               cfg_ff.center_speed <= csr_wdata[lscs_pkg::SPEED_W-1:0];
            lscs_pkg::CSR_TIMEOUT_MS:
               cfg_ff.timeout_ms <= csr_wdata[lscs_pkg::TIME_W-1:0];
            lscs_pkg::CSR_OVER_LINE_LEVEL:
               cfg_ff.over_line_level <= csr_wdata[lscs_pkg::LEVEL_W-1:0];
            lscs_pkg::CSR_NO_LINE_LEVEL:
               cfg_ff.no_line_level <= csr_wdata[lscs_pkg::LEVEL_W-1:0];
            default: ;
         endcase
      end
   end

   // handshake: move the input stage on when the result stage is free
   assign advance    = item_valid_ff && (!rsp_valid_ff || rsp_tready);
   assign req_tready = !item_valid_ff || advance;
   assign req_take   = req_tvalid && req_tready;
   assign rsp_tvalid = rsp_valid_ff;

   // unpack the request
   assign item_in.restart         = req_tdata[0];
   assign item_in.ms_tick         = req_tdata[1];
   assign item_in.left_level      = req_tdata[11:2];
   assign item_in.mid_left_level  = req_tdata[21:12];
   assign item_in.mid_level       = req_tdata[31:22];
   assign item_in.mid_right_level = req_tdata[41:32];
   assign item_in.right_level     = req_tdata[51:42];
   assign item_in.left_cal_ok     = req_tdata[52];
   assign item_in.right_cal_ok    = req_tdata[53];
   assign item_in.all_cal_ok      = req_tdata[54];

   lscs_step u_step (
      .cfg  (cfg_ff),
      .item (item_ff),
      .cur  (state_ff),
      .nxt  (state_in),
      .rsp  (rsp_in)
   );

   // input stage
   always_ff @(posedge clock) begin
      if (reset) begin
         item_valid_ff <= 1'b0;
      end else if (req_tready) begin
         item_valid_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         item_ff <= item_in;
      end
   end

   // sequencer state advances with each processed transaction
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff.phase     <= lscs_pkg::PH_WAIT;
         state_ff.time_left <= '0;
      end else if (advance) begin
         state_ff <= state_in;
      end
   end

   // result stage
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_ff <= rsp_in;
      end
   end

   // pack the result
   assign rsp_tdata = {1'b0, rsp_ff.event_code, rsp_ff.cal_end, rsp_ff.cal_begin,
                       rsp_ff.right_reverse, rsp_ff.right_speed, rsp_ff.left_reverse,
                       rsp_ff.left_speed, rsp_ff.drive_valid};

endmodule

`default_nettype wire
